// ===== rtl/htf_pkg.sv =====
// ----------------------------------------------------------------------------
// htf_pkg
// Shared types, constants and the CRC-16 bit step of the HDLC transmit framer.
// ----------------------------------------------------------------------------
package htf_pkg;

  localparam logic [7:0]  HDLC_FLAG      = 8'h7E;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [2:0]  RUN_LIMIT      = 3'd5;
  localparam logic [15:0] CRC_INIT_RST   = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT_RST = 16'h0000;

  // configuration register indexes
  localparam logic CFG_CRC_INIT   = 1'b0;
  localparam logic CFG_CRC_XOROUT = 1'b1;

  // request from the sequencer to the CRC unit
  typedef struct packed {
    logic       load;   // new byte accepted
    logic       start;  // byte opens a frame: seed from crc_init
    logic [7:0] data;
  } crc_req_t;

  // one MSB-first step of the CRC-16 shift register
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic b);
    logic fb;
    fb = c[15] ^ b;
    crc_step = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
  endfunction

endpackage

// ===== rtl/htf_if.sv =====
// ----------------------------------------------------------------------------
// htf_in_if / htf_out_if
// Valid/ready channels for payload bytes and for serial line bits.
// ----------------------------------------------------------------------------
interface htf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface htf_out_if;
  logic valid;
  logic ready;
  logic line_bit;
  logic stuffed_zero;
  logic frame_done;
  logic item_last;

  modport source (output valid, output line_bit, output stuffed_zero,
                  output frame_done, output item_last, input ready);
  modport sink   (input valid, input line_bit, input stuffed_zero,
                  input frame_done, input item_last, output ready);
endinterface

// ===== rtl/htf_crc.sv =====
// ----------------------------------------------------------------------------
// htf_crc
// Bit-serial CRC-16 (poly 0x1021, MSB first). One byte folds in bit by bit,
// the first bit on the load edge itself.
// ----------------------------------------------------------------------------
module htf_crc
  import htf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  crc_req_t    req,
  input  logic [15:0] crc_init,
  output logic [15:0] crc
);

  logic [15:0] crc_r, crc_nxt;
  logic [6:0]  sh_r, sh_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] base;

  assign base = req.start ? crc_init : crc_r;
  assign crc  = crc_r;

  always_comb begin
    crc_nxt = crc_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (req.load) begin
      crc_nxt = crc_step(base, req.data[7]);
      sh_nxt  = req.data[6:0];
      cnt_nxt = 3'd7;
    end else if (cnt_r != 3'd0) begin
      crc_nxt = crc_step(crc_r, sh_r[6]);
      sh_nxt  = {sh_r[5:0], 1'b0};
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      crc_r <= CRC_INIT_RST;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
    sh_r <= sh_nxt;
  end

endmodule

// ===== rtl/htf_ser.sv =====
// ----------------------------------------------------------------------------
// htf_ser
// Frame sequencer and bit stuffer: shifts flags, data and FCS into the output
// register one bit per unstalled cycle, inserting a zero after five ones.
// ----------------------------------------------------------------------------
module htf_ser
  import htf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  htf_in_if.sink      in_ch,
  htf_out_if.source   out_ch,
  input  logic [15:0] crc,
  input  logic [15:0] crc_xorout,
  output crc_req_t    crc_req
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FLAG_O = 3'd1;
  localparam logic [2:0] ST_DATA   = 3'd2;
  localparam logic [2:0] ST_FCS    = 3'd3;
  localparam logic [2:0] ST_FLAG_C = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] shift_r, shift_nxt;
  logic [2:0]  ones_r, ones_nxt;
  logic        pend_r, pend_nxt;
  logic        last_r, last_nxt;
  logic        in_frame_r, in_frame_nxt;

  logic        ov_r, ov_nxt;
  logic        obit_r, obit_nxt;
  logic        ostuff_r, ostuff_nxt;
  logic        odone_r, odone_nxt;
  logic        olast_r, olast_nxt;

  logic adv, gen, accept, stuffable, bit_val, new_pend, phase_end;

  assign in_ch.ready = (st_r == ST_IDLE) && !pend_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign adv         = !ov_r || out_ch.ready;
  assign gen         = adv && (pend_r || (st_r != ST_IDLE));
  assign stuffable   = (st_r == ST_DATA) || (st_r == ST_FCS);

  assign crc_req.load  = accept;
  assign crc_req.start = !in_frame_r;
  assign crc_req.data  = in_ch.data_byte;

  always_comb begin
    case (st_r)
      ST_DATA: bit_val = shift_r[0];
      ST_FCS:  bit_val = shift_r[15];
      default: bit_val = HDLC_FLAG[idx_r[2:0]];
    endcase
    phase_end = (st_r == ST_FCS) ? (idx_r == 4'd15) : (idx_r == 4'd7);
    new_pend  = stuffable && bit_val && (ones_r == RUN_LIMIT - 3'd1);
  end

  always_comb begin
    st_nxt       = st_r;
    idx_nxt      = idx_r;
    shift_nxt    = shift_r;
    ones_nxt     = ones_r;
    pend_nxt     = pend_r;
    last_nxt     = last_r;
    in_frame_nxt = in_frame_r;
    ov_nxt       = ov_r && !out_ch.ready;
    obit_nxt     = obit_r;
    ostuff_nxt   = ostuff_r;
    odone_nxt    = odone_r;
    olast_nxt    = olast_r;

    if (accept) begin
      shift_nxt    = {8'h00, in_ch.data_byte};
      last_nxt     = in_ch.last_byte;
      idx_nxt      = 4'd0;
      in_frame_nxt = 1'b1;
      if (!in_frame_r) begin
        st_nxt   = ST_FLAG_O;
        ones_nxt = 3'd0;
      end else begin
        st_nxt = ST_DATA;
      end
    end

    if (gen) begin
      ov_nxt = 1'b1;
      if (pend_r) begin
        // inserted zero; state already moved past the bit that caused it
        obit_nxt   = 1'b0;
        ostuff_nxt = 1'b1;
        odone_nxt  = 1'b0;
        olast_nxt  = (st_r == ST_IDLE);
        pend_nxt   = 1'b0;
      end else begin
        obit_nxt   = bit_val;
        ostuff_nxt = 1'b0;
        odone_nxt  = 1'b0;
        olast_nxt  = 1'b0;
        idx_nxt    = idx_r + 4'd1;
        if (stuffable) begin
          pend_nxt = new_pend;
          if (!bit_val || new_pend) begin
            ones_nxt = 3'd0;
          end else begin
            ones_nxt = ones_r + 3'd1;
          end
        end
        case (st_r)
          ST_FLAG_O: begin
            if (phase_end) begin
              st_nxt  = ST_DATA;
              idx_nxt = 4'd0;
            end
          end
          ST_DATA: begin
            shift_nxt = {1'b0, shift_r[15:1]};
            if (phase_end) begin
              idx_nxt = 4'd0;
              if (last_r) begin
                st_nxt    = ST_FCS;
                shift_nxt = crc ^ crc_xorout;
              end else begin
                st_nxt    = ST_IDLE;
                olast_nxt = !new_pend;
              end
            end
          end
          ST_FCS: begin
            shift_nxt = {shift_r[14:0], 1'b0};
            if (phase_end) begin
              st_nxt  = ST_FLAG_C;
              idx_nxt = 4'd0;
            end
          end
          ST_FLAG_C: begin
            if (phase_end) begin
              st_nxt       = ST_IDLE;
              idx_nxt      = 4'd0;
              in_frame_nxt = 1'b0;
              ones_nxt     = 3'd0;
              odone_nxt    = 1'b1;
              olast_nxt    = 1'b1;
            end
          end
          default: st_nxt = ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      idx_r      <= 4'd0;
      ones_r     <= 3'd0;
      pend_r     <= 1'b0;
      in_frame_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      idx_r      <= idx_nxt;
      ones_r     <= ones_nxt;
      pend_r     <= pend_nxt;
      in_frame_r <= in_frame_nxt;
      ov_r       <= ov_nxt;
    end
    shift_r  <= shift_nxt;
    last_r   <= last_nxt;
    obit_r   <= obit_nxt;
    ostuff_r <= ostuff_nxt;
    odone_r  <= odone_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.line_bit     = obit_r;
  assign out_ch.stuffed_zero = ostuff_r;
  assign out_ch.frame_done   = odone_r;
  assign out_ch.item_last    = olast_r;

endmodule

// ===== rtl/hdlc_tx_framer_core.sv =====
// ----------------------------------------------------------------------------
// hdlc_tx_framer_core
// HDLC transmit framer: flags, bit stuffing and CRC-16 FCS, one line bit per
// output request.
// ----------------------------------------------------------------------------
// Bytes come in LSB first order on in_ch with last_byte marking the end of a
// packet; out_ch delivers one line bit per request. The output register emits
// at most one bit per cycle, so a byte costs its 8 data bits plus one per
// stuffed zero, plus the byte handshake itself (the next byte is taken
// only after every bit of the current one has left the sequencer). A byte
// that opens a frame adds the 8-bit opening flag; a last byte adds 16 FCS
// bits (plus stuffing) and the 8-bit closing flag. The CRC folds each byte
// in bit-serially alongside the data bits. crc_init is sampled at frame
// start; crc_xorout when the FCS is loaded.
module hdlc_tx_framer_core
  import htf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  htf_in_if.sink      in_ch,
  htf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] crc_init_r;
  logic [15:0] crc_xorout_r;
  logic [15:0] crc;
  crc_req_t    crc_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r   <= CRC_INIT_RST;
      crc_xorout_r <= CRC_XOROUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_INIT:   crc_init_r   <= cfg_data;
        CFG_CRC_XOROUT: crc_xorout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  htf_crc u_crc (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (crc_req),
    .crc_init (crc_init_r),
    .crc      (crc)
  );

  htf_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .crc        (crc),
    .crc_xorout (crc_xorout_r),
    .crc_req    (crc_req)
  );

endmodule

// ===== rtl/htf_chk.sv =====
// ----------------------------------------------------------------------------
// htf_chk
// Port-level checks for the HDLC transmit framer, bound to the top level.
// ----------------------------------------------------------------------------
module htf_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_bit,
  input logic out_stuffed_zero,
  input logic out_frame_done,
  input logic out_item_last
);

  // a stalled line bit stays on offer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  // closing flag ends the request of the last byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_item_last && !out_stuffed_zero)
    else $error("frame_done without item_last");

  // stuffing only ever inserts zeros
  a_stuff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stuffed_zero |-> !out_line_bit)
    else $error("stuffed bit is not zero");

  // a byte always produces bits, so the input closes right after a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a byte was taken");

endmodule

bind hdlc_tx_framer_core htf_chk u_htf_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_line_bit     (out_ch.line_bit),
  .out_stuffed_zero (out_ch.stuffed_zero),
  .out_frame_done   (out_ch.frame_done),
  .out_item_last    (out_ch.item_last)
);
